FILE: src/scr_pkg.sv
// Package: constants, command codes and the CRC byte step for the command responder.
package scr_pkg;

    localparam int FRAME_BYTES = 7;
    localparam int BANK_BYTES  = 256;
    localparam int FB_AW       = $clog2(FRAME_BYTES);
    localparam int BANK_AW     = $clog2(BANK_BYTES);
    localparam int STORE_AW    = BANK_AW + 1;
    localparam int STORE_DEPTH = 2 * BANK_BYTES;

    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] VOLT_RESET = 16'd13919;
    localparam logic [3:0]  COUNT_MAX  = 4'd15;

    localparam logic [7:0] CMD_ZERO  = 8'h02;
    localparam logic [7:0] CMD_STAT  = 8'h04;
    localparam logic [7:0] CMD_VOLT  = 8'h07;
    localparam logic [7:0] CMD_WR1   = 8'h30;
    localparam logic [7:0] CMD_RD1   = 8'h40;
    localparam logic [7:0] CMD_ECHO  = 8'h50;
    localparam logic [7:0] CMD_WR2   = 8'h60;
    localparam logic [7:0] CMD_RD2   = 8'h70;
    localparam logic [7:0] CMD_WR4   = 8'h80;
    localparam logic [7:0] CMD_RD4   = 8'h90;
    localparam logic [7:0] CMD_LOW_LIMIT = 8'h20;
    localparam logic [3:0] PAGE_HIGH = 4'hF;

    // Store request from the sequencer to the store.
    typedef struct packed {
        logic                wr;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          wdata;
    } store_req_t;

    // One byte through the CRC-16/XMODEM register, eight dependent shifts.
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (r[15]) r = {r[14:0], 1'b0} ^ CRC_POLY;
            else       r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: src/scr_store.sv
// Two-bank byte store: synchronous memory with a clearing sweep after reset.
module scr_store (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  scr_pkg::store_req_t                 req,
    output logic [7:0]                          rdata,
    output logic                                clr_busy
);
    logic [7:0] mem [scr_pkg::STORE_DEPTH];
    logic [scr_pkg::STORE_AW-1:0] clr_addr_reg, clr_addr_next;
    logic                         clr_busy_reg, clr_busy_next;

    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg) clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) mem[clr_addr_reg] <= 8'h00;
        else if (req.wr)  mem[req.addr] <= req.wdata;
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[req.addr];
    end

    assign clr_busy = clr_busy_reg;

    a_clr_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (clr_busy_reg && (&clr_addr_reg)) |=> !clr_busy_reg)
        else $error("clearing sweep did not end");
    a_clr_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !clr_busy_reg |=> !clr_busy_reg)
        else $error("clearing sweep restarted");
    a_clr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (clr_busy_reg && !(&clr_addr_reg)) |=> clr_addr_reg == $past(clr_addr_reg) + 1'b1)
        else $error("clearing address skipped");
endmodule

FILE: src/serial_command_responder_crc_store_top.sv
// Top level: frame intake, check, store access and response sequencer.
//
// Frame bytes arrive on the s_ stream (tdata = rx_byte, tlast = frame_end); the first
// seven are kept. A non-last byte does not hold the input. At the last byte the block checks
// length and check byte (one CRC byte step per cycle over up to six bytes), performs
// store writes or reads one byte a cycle through the single store port (read data
// registered in the store), builds the reply CRC a byte a cycle while bytes leave, as
// the output register frees, and streams up to six response bytes on the m_ side (tdata =
// tx_byte, tlast = tx_last). A frame end holds the input until the check, any store
// accesses and the response are done, and output back-pressure lengthens the hold.
// After reset the 512-byte store is cleared by a sweep during which no byte is
// accepted; configuration writes (voltage_report) are taken at any time.
module serial_command_responder_crc_store_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] tx_byte
    output logic        m_tlast,   // tx_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    localparam logic [2:0] ST_RX   = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_MEM  = 3'd2;
    localparam logic [2:0] ST_MEMW = 3'd3;
    localparam logic [2:0] ST_TX   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  fb_reg [scr_pkg::FRAME_BYTES];
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  n_reg, n_next;
    logic [15:0] volt_reg, volt_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  r_reg [6];
    logic [7:0]  r_next [6];
    logic [2:0]  len_reg, len_next;     // reply bytes before the CRC
    logic [2:0]  mcnt_reg, mcnt_next;   // store operations issued
    logic        rdv_reg, rdv_next;     // read data due this cycle
    logic [2:0]  mslot_reg, mslot_next;
    logic        outv_reg, outv_next;
    logic [7:0]  outd_reg, outd_next;
    logic        outl_reg, outl_next;

    logic [7:0]  cmd, page_b;
    logic [3:0]  page;
    logic [3:0]  need;
    logic [2:0]  kpos;
    logic [2:0]  wr_n, rd_n;
    logic        isrd, iswr;
    scr_pkg::store_req_t req;
    logic [7:0]  rdata;
    logic        clr_busy;
    logic        s_acc;
    logic [scr_pkg::FB_AW-1:0] cnt_ix;

    scr_store u_store (.aclk(aclk), .aresetn(aresetn), .req(req), .rdata(rdata),
                       .clr_busy(clr_busy));

    // Decode command, page and frame geometry from the held frame.
    always_comb begin
        page_b = fb_reg[0];
        if (page_b < scr_pkg::CMD_LOW_LIMIT) begin
            cmd  = page_b;
            page = 4'h0;
        end else begin
            cmd  = {page_b[7:4], 4'h0};
            page = page_b[3:0];
        end
        need = 4'd4; kpos = 3'd3;
        if (cmd == scr_pkg::CMD_WR2) begin need = 4'd5; kpos = 3'd4; end
        if (cmd == scr_pkg::CMD_WR4) begin need = 4'd7; kpos = 3'd6; end
        wr_n = 3'd0; rd_n = 3'd0;
        case (cmd)
            scr_pkg::CMD_WR1: wr_n = 3'd1;
            scr_pkg::CMD_WR2: wr_n = 3'd2;
            scr_pkg::CMD_WR4: wr_n = 3'd4;
            scr_pkg::CMD_RD1: rd_n = 3'd1;
            scr_pkg::CMD_RD2: rd_n = 3'd2;
            scr_pkg::CMD_RD4: rd_n = 3'd4;
            default: ;
        endcase
        iswr = (wr_n != 3'd0);
        isrd = (rd_n != 3'd0);
    end

    assign s_acc  = s_tvalid && s_tready;
    assign cnt_ix = cnt_reg[scr_pkg::FB_AW-1:0];

    always_comb begin
        logic [scr_pkg::BANK_AW-1:0] off;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        crc_next   = crc_reg;
        idx_next   = idx_reg;
        r_next     = r_reg;
        len_next   = len_reg;
        mcnt_next  = mcnt_reg;
        rdv_next   = 1'b0;
        mslot_next = mslot_reg;
        outv_next  = outv_reg;
        outd_next  = outd_reg;
        outl_next  = outl_reg;
        volt_next  = cfg_valid ? cfg_data : volt_reg;
        off = fb_reg[1][scr_pkg::BANK_AW-1:0] + scr_pkg::BANK_AW'(mcnt_reg);
        req.wr    = 1'b0;
        req.addr  = {(page == scr_pkg::PAGE_HIGH), off};
        req.wdata = fb_reg[3'd2 + mcnt_reg];

        if (outv_reg && m_tready) outv_next = 1'b0;

        unique case (state_reg)
            ST_RX: begin
                if (s_acc) begin
                    if (s_tlast) begin
                        n_next     = (cnt_reg < scr_pkg::COUNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
                        cnt_next   = 4'd0;
                        crc_next   = 16'h0000;
                        idx_next   = 3'd0;
                        state_next = ST_CHK;
                    end else if (cnt_reg < scr_pkg::COUNT_MAX) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_CHK: begin
                if (n_reg < need) begin
                    state_next = ST_RX;
                end else if (idx_reg == kpos) begin
                    if (crc_reg[7:0] != fb_reg[kpos]) begin
                        state_next = ST_RX;
                    end else begin
                        len_next   = 3'd0;
                        mcnt_next  = 3'd0;
                        mslot_next = 3'd1;
                        state_next = ST_RX;
                        case (cmd)
                            scr_pkg::CMD_ZERO: begin
                                r_next[0] = 8'h00; r_next[1] = 8'h00; len_next = 3'd2;
                                state_next = ST_TX;
                            end
                            scr_pkg::CMD_STAT: begin
                                r_next[0] = (fb_reg[1] == 8'h00) ? 8'h01 : 8'h00;
                                r_next[1] = (fb_reg[1] == 8'h00) ? 8'h01 : 8'h00;
                                r_next[2] = 8'h00; len_next = 3'd3;
                                state_next = ST_TX;
                            end
                            scr_pkg::CMD_VOLT: begin
                                r_next[0] = volt_reg[7:0]; r_next[1] = volt_reg[15:8];
                                r_next[2] = 8'h00; len_next = 3'd3;
                                state_next = ST_TX;
                            end
                            scr_pkg::CMD_ECHO: begin
                                r_next[0] = fb_reg[1]; r_next[1] = 8'h00; len_next = 3'd2;
                                state_next = ST_TX;
                            end
                            default: begin
                                if (iswr || isrd) begin
                                    r_next[0] = fb_reg[1];
                                    for (int i = 1; i < 6; i++) r_next[i] = fb_reg[i+1];
                                    len_next   = (iswr ? wr_n : rd_n) + 3'd1;
                                    state_next = ST_MEM;
                                end
                            end
                        endcase
                        crc_next = 16'h0000;
                        idx_next = 3'd0;
                    end
                end else begin
                    crc_next = scr_pkg::crc_step(crc_reg, fb_reg[idx_reg]);
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MEM: begin
                // One store access a cycle; read data lands in the next cycle.
                if (rdv_reg) begin
                    r_next[mslot_reg] = rdata;
                    mslot_next = mslot_reg + 1'b1;
                end
                if (mcnt_reg < (iswr ? wr_n : rd_n)) begin
                    req.wr    = iswr;
                    rdv_next  = isrd;
                    mcnt_next = mcnt_reg + 1'b1;
                end else if (!rdv_reg) begin
                    state_next = ST_TX;
                end
            end
            ST_TX: begin
                if (!outv_reg || m_tready) begin
                    outv_next = 1'b1;
                    if (idx_reg == len_reg) begin
                        outd_next  = crc_reg[7:0];
                        outl_next  = 1'b1;
                        state_next = ST_RX;
                    end else begin
                        outd_next = r_reg[idx_reg];
                        outl_next = 1'b0;
                        crc_next  = scr_pkg::crc_step(crc_reg, r_reg[idx_reg]);
                        idx_next  = idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_RX;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RX;
            cnt_reg   <= 4'd0;
            volt_reg  <= scr_pkg::VOLT_RESET;
            outv_reg  <= 1'b0;
            rdv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            volt_reg  <= volt_next;
            outv_reg  <= outv_next;
            rdv_reg   <= rdv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && (cnt_reg < 4'(scr_pkg::FRAME_BYTES))) fb_reg[cnt_ix] <= s_tdata;
        n_reg     <= n_next;
        crc_reg   <= crc_next;
        idx_reg   <= idx_next;
        r_reg     <= r_next;
        len_reg   <= len_next;
        mcnt_reg  <= mcnt_next;
        mslot_reg <= mslot_next;
        outd_reg  <= outd_next;
        outl_reg  <= outl_next;
    end

    assign s_tready  = (state_reg == ST_RX) && !clr_busy;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = outv_reg;
    assign m_tdata   = outd_reg;
    assign m_tlast   = outl_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("response byte dropped under stall");
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_tready)
        else $error("byte accepted during clearing sweep");
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (cnt_reg == 4'd0 && state_reg == ST_CHK))
        else $error("frame end did not restart frame");
endmodule

FILE: test/tb_responder_checker.sv
// Checker: predicts responder replies from observed transactions and compares them.
`timescale 1ns / 100ps

module tb_responder_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_replies,
    output int          reply_count
);

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } reply_byte_t;

    logic [7:0]  frame_q [scr_pkg::FRAME_BYTES];
    logic [3:0]  rx_count;
    logic [7:0]  store_mem [scr_pkg::STORE_DEPTH];
    logic [15:0] volt_reg;
    reply_byte_t reply_q [$];

    assign pending_replies = reply_q.size();

    function automatic logic [7:0] crc_low_of(input logic [7:0] d [6], input int n);
        logic [15:0] c;
        c = 16'h0000;
        for (int i = 0; i < n; i++) begin
            c = c ^ {d[i], 8'h00};
            for (int b = 0; b < 8; b++)
                c = c[15] ? ({c[14:0], 1'b0} ^ scr_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c[7:0];
    endfunction

    // Apply one frame byte to the predicted state; queue any reply at frame end.
    task automatic predict_byte(input logic [7:0] rx, input logic last);
        logic [7:0] cmd, addr;
        logic [7:0] chk [6];
        logic [7:0] rep [6];
        int n, need, k, len, wr, rd;
        logic [scr_pkg::STORE_AW-1:0] bank;
        len = 0; wr = 0; rd = 0;
        if (rx_count < 4'(scr_pkg::FRAME_BYTES))
            frame_q[rx_count[scr_pkg::FB_AW-1:0]] = rx;
        if (rx_count < scr_pkg::COUNT_MAX) rx_count = rx_count + 4'd1;
        if (!last) return;
        n = int'(rx_count);
        rx_count = '0;
        cmd = (frame_q[0] < scr_pkg::CMD_LOW_LIMIT) ? frame_q[0] : (frame_q[0] & 8'hF0);
        bank = (frame_q[0] >= scr_pkg::CMD_LOW_LIMIT && frame_q[0][3:0] == scr_pkg::PAGE_HIGH)
               ? scr_pkg::STORE_AW'(scr_pkg::BANK_BYTES) : '0;
        if (cmd == scr_pkg::CMD_WR2) begin need = 5; k = 4; end
        else if (cmd == scr_pkg::CMD_WR4) begin need = 7; k = 6; end
        else begin need = 4; k = 3; end
        if (n < need) return;
        for (int i = 0; i < 6; i++) chk[i] = frame_q[i];
        if (crc_low_of(chk, k) != frame_q[k]) return;
        addr = frame_q[1];
        case (cmd)
            scr_pkg::CMD_ZERO: begin rep[0] = 8'h00; rep[1] = 8'h00; len = 2; end
            scr_pkg::CMD_STAT: begin
                rep[0] = (addr == 8'h00) ? 8'd1 : 8'd0; rep[1] = rep[0]; rep[2] = 8'h00;
                len = 3;
            end
            scr_pkg::CMD_VOLT: begin
                rep[0] = volt_reg[7:0]; rep[1] = volt_reg[15:8]; rep[2] = 8'h00; len = 3;
            end
            scr_pkg::CMD_WR1: wr = 1;
            scr_pkg::CMD_WR2: wr = 2;
            scr_pkg::CMD_WR4: wr = 4;
            scr_pkg::CMD_RD1: rd = 1;
            scr_pkg::CMD_RD2: rd = 2;
            scr_pkg::CMD_RD4: rd = 4;
            scr_pkg::CMD_ECHO: begin rep[0] = addr; rep[1] = 8'h00; len = 2; end
            default: ;
        endcase
        for (int i = 0; i < wr; i++)
            store_mem[bank + scr_pkg::STORE_AW'(8'(addr + i))] = frame_q[2 + i];
        if (wr > 0) begin
            for (int i = 0; i <= wr; i++) rep[i] = frame_q[1 + i];
            len = wr + 1;
        end
        if (rd > 0) begin
            rep[0] = addr;
            for (int i = 0; i < rd; i++)
                rep[1 + i] = store_mem[bank + scr_pkg::STORE_AW'(8'(addr + i))];
            len = rd + 1;
        end
        if (len == 0) return;
        rep[len] = crc_low_of(rep, len);
        for (int i = 0; i <= len; i++) reply_q.push_back('{rep[i], i == len});
    endtask

    always @(posedge aclk) begin
        reply_byte_t want;
        if (!aresetn) begin
            rx_count <= '0;
            volt_reg <= scr_pkg::VOLT_RESET;
            fail_count <= 0;
            reply_count <= 0;
            for (int i = 0; i < scr_pkg::STORE_DEPTH; i++) store_mem[i] = 8'h00;
            for (int i = 0; i < scr_pkg::FRAME_BYTES; i++) frame_q[i] = 8'h00;
            reply_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) volt_reg <= cfg_data;
            if (m_tvalid && m_tready) begin
                reply_count <= reply_count + 1;
                if (reply_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected reply byte %h last %b", m_tdata, m_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    want = reply_q.pop_front();
                    if (want.tx_byte !== m_tdata || want.tx_last !== m_tlast) begin
                        if (fail_count < 10)
                            $display("reply mismatch: expected %h/%b got %h/%b",
                                     want.tx_byte, want.tx_last, m_tdata, m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
        end
    end

endmodule

FILE: test/tb_top.sv
// Testbench top: frame stimulus, configuration phases and verdict for the responder.
`timescale 1ns / 100ps

module tb_top;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready, s_tlast;
    logic [7:0]  s_tdata;
    logic        m_tvalid, m_tready, m_tlast;
    logic [7:0]  m_tdata;
    logic        cfg_valid, cfg_ready;
    logic [15:0] cfg_data;
    int          fail_count, pending_replies, reply_count;
    int          cycle_count;
    int          items_sent;
    int          burst_left;

    localparam int CYCLE_LIMIT = 400000;

    serial_command_responder_crc_store_top i_dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .cfg_valid, .cfg_ready, .cfg_data
    );

    tb_responder_checker i_checker (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // Receiver stall pattern: long free runs alternate with random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (cycle_count[9]) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Abort on a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[serial_command_responder_crc_store_top] ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] crc8_low(input logic [7:0] d [7], input int n);
        logic [15:0] c;
        c = 16'h0000;
        for (int i = 0; i < n; i++) c = scr_pkg::crc_step(c, d[i]);
        return c[7:0];
    endfunction

    // Send one byte as a transaction; insert a random gap between bursts.
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    task automatic push_frame(input logic [7:0] d [7], input int n);
        for (int i = 0; i < n; i++) push_byte(d[i], i == n - 1);
    endtask

    // Build a well-formed frame for a command, then send it, optionally corrupted.
    task automatic send_command(input logic [7:0] head, input logic [7:0] addr, input bit corrupt);
        logic [7:0] d [7];
        int k, n;
        for (int i = 0; i < 7; i++) d[i] = 8'($urandom);
        d[0] = head;
        d[1] = addr;
        if (head >= scr_pkg::CMD_LOW_LIMIT && head[7:4] == scr_pkg::CMD_WR2[7:4]) k = 4;
        else if (head >= scr_pkg::CMD_LOW_LIMIT && head[7:4] == scr_pkg::CMD_WR4[7:4]) k = 6;
        else k = 3;
        d[k] = crc8_low(d, k);
        if (corrupt) d[k] = d[k] ^ 8'(1 << $urandom_range(0, 7));
        n = k + 1;
        // occasionally trail extra bytes, up to saturating the count
        if ($urandom_range(0, 5) == 0) n = $urandom_range(k + 1, 18);
        if (n <= 7) push_frame(d, n);
        else begin
            for (int i = 0; i < 7; i++) push_byte(d[i], 1'b0);
            for (int i = 7; i < n; i++) push_byte(8'($urandom), i == n - 1);
        end
    endtask

    // Wait until every reply has left, then let the block settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_replies != 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_voltage(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_head();
        logic [7:0] cmds [10] = '{scr_pkg::CMD_ZERO, scr_pkg::CMD_STAT, scr_pkg::CMD_VOLT,
                                  scr_pkg::CMD_WR1, scr_pkg::CMD_RD1, scr_pkg::CMD_ECHO,
                                  scr_pkg::CMD_WR2, scr_pkg::CMD_RD2, scr_pkg::CMD_WR4,
                                  scr_pkg::CMD_RD4};
        logic [7:0] h;
        h = cmds[$urandom_range(0, 9)];
        if (h >= scr_pkg::CMD_LOW_LIMIT)
            h[3:0] = ($urandom_range(0, 1) != 0) ? scr_pkg::PAGE_HIGH : 4'($urandom);
        return h;
    endfunction

    initial begin
        logic [7:0] d [7];
        logic [15:0] volt_set [4] = '{16'h0000, 16'hFFFF, 16'hA55A, 16'h365F};
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 16'h0000;
        cycle_count = 0;
        items_sent  = 0;
        burst_left  = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every command, extreme addresses, bad frames, unknown command.
        send_command(scr_pkg::CMD_VOLT, 8'h00, 0);
        send_command(scr_pkg::CMD_ZERO, 8'hFF, 0);
        send_command(scr_pkg::CMD_STAT, 8'h00, 0);
        send_command(scr_pkg::CMD_STAT, 8'h01, 0);
        send_command(scr_pkg::CMD_WR4 | 8'h0F, 8'hFE, 0);   // wraps within the upper bank
        send_command(scr_pkg::CMD_RD4 | 8'h0F, 8'hFE, 0);
        send_command(scr_pkg::CMD_RD4, 8'hFE, 0);           // lower bank still zero
        send_command(scr_pkg::CMD_WR2, 8'hFF, 0);
        send_command(scr_pkg::CMD_RD2 | 8'h03, 8'hFF, 0);
        send_command(scr_pkg::CMD_WR1, 8'h80, 0);
        send_command(scr_pkg::CMD_RD1, 8'h80, 0);
        send_command(scr_pkg::CMD_ECHO, 8'hFF, 0);
        send_command(scr_pkg::CMD_WR1, 8'h10, 1);           // bad check byte
        send_command(8'h18, 8'h00, 0);                      // unknown command
        d = '{scr_pkg::CMD_WR4, 8'h00, 8'h11, 8'h22, 8'h00, 8'h00, 8'h00};
        push_frame(d, 3);                                   // short frame
        d = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        push_frame(d, 1);
        drain();   // sender holds off until all replies are out

        // Random phases, one voltage setting each.
        for (int ph = 0; ph < 4; ph++) begin
            write_voltage(volt_set[ph]);
            while (items_sent < 120 + 60 * (ph + 1)) begin
                case ($urandom_range(0, 9))
                    0: send_command(pick_head(), 8'($urandom), 1);
                    1: begin
                        for (int i = 0; i < 7; i++) d[i] = 8'($urandom);
                        push_frame(d, $urandom_range(1, 7));
                    end
                    default: send_command(pick_head(),
                                          ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom), 0);
                endcase
            end
            drain();
        end

        $display("sent %0d frame bytes over four voltage settings, %0d reply bytes checked",
                 items_sent, reply_count);
        if (fail_count == 0) begin
            $display("[serial_command_responder_crc_store_top] OK");
        end else begin
            $display("[serial_command_responder_crc_store_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
src/scr_pkg.sv
src/scr_store.sv
src/serial_command_responder_crc_store_top.sv
test/tb_responder_checker.sv
test/tb_top.sv
